// ===== design/ffcv_pkg.sv =====
// shared types and codes for the framed fletcher checksum verifier
package ffcv_pkg;

   localparam int ByteBits = 8;
   localparam logic [ByteBits-1:0] SYNC_BYTE = 8'h65;

   // frame parser phases
   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_TYPE    = 3'd1;
   localparam logic [2:0] PH_LEN_LO  = 3'd2;
   localparam logic [2:0] PH_LEN_HI  = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CHECK_A = 3'd5;
   localparam logic [2:0] PH_CHECK_B = 3'd6;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_MISMATCH = 2'd1;
   localparam logic [1:0] ST_BAD_SYNC = 2'd2;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] payload_length;
      logic [7:0]  sum_a;
      logic [7:0]  sum_b;
   } result_type;

endpackage

// ===== design/framed_fletcher_checksum_verifier_top.sv =====
// Framed Fletcher-8 checksum verifier: takes one byte per cycle while req_stall is low; a
// frame is the sync byte 0x65, a type byte, a little-endian 16-bit payload length, the
// payload and two check bytes. Sums A and B cover type, length and payload. One result
// leaves after the second check byte (status 0 good, 1 mismatch), and one for every
// non-sync byte seen while hunting (status 2, other fields zero). A sync byte inside a
// frame is plain data. Results go to an output register backed by a one-entry skid
// stage, so bytes keep flowing while a result waits, and req_stall rises only once that
// skid stage is also holding a result.
module framed_fletcher_checksum_verifier_top
   import ffcv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_payload_length,
   output logic [7:0]  rsp_sum_a,
   output logic [7:0]  rsp_sum_b
);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  run_a_ff, run_a_in;
   logic [7:0]  run_b_ff, run_b_in;
   logic [7:0]  recv_a_ff, recv_a_in;

   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   result_type  skid_ff, skid_in;

   logic        accept;
   logic        res_valid;
   result_type  res;
   logic [7:0]  acc_a;
   logic [7:0]  acc_b;
   logic [15:0] left_dec;
   logic        drain;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign acc_a     = run_a_ff + req_data_byte;
   assign acc_b     = run_b_ff + acc_a;
   assign left_dec  = left_ff - 16'd1;

   // frame parser
   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      left_in   = left_ff;
      run_a_in  = run_a_ff;
      run_b_in  = run_b_ff;
      recv_a_in = recv_a_ff;
      res_valid = 1'b0;
      res       = '0;
      if (accept) begin
         case (phase_ff)
            PH_TYPE: begin
               run_a_in = acc_a;
               run_b_in = acc_b;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               run_a_in  = acc_a;
               run_b_in  = acc_b;
               length_in = {8'd0, req_data_byte};
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               run_a_in  = acc_a;
               run_b_in  = acc_b;
               length_in = {req_data_byte, length_ff[7:0]};
               left_in   = {req_data_byte, length_ff[7:0]};
               phase_in  = ({req_data_byte, length_ff[7:0]} == 16'd0) ? PH_CHECK_A
                                                                       : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               run_a_in = acc_a;
               run_b_in = acc_b;
               left_in  = left_dec;
               if (left_dec == 16'd0) begin
                  phase_in = PH_CHECK_A;
               end
            end
            PH_CHECK_A: begin
               recv_a_in = req_data_byte;
               phase_in  = PH_CHECK_B;
            end
            PH_CHECK_B: begin
               res_valid          = 1'b1;
               res.status         = (recv_a_ff == run_a_ff && req_data_byte == run_b_ff)
                                    ? ST_OK : ST_MISMATCH;
               res.payload_length = length_ff;
               res.sum_a          = run_a_ff;
               res.sum_b          = run_b_ff;
               phase_in           = PH_HUNT;
            end
            default: begin
               // hunting, unused code behaves the same
               if (req_data_byte == SYNC_BYTE) begin
                  run_a_in  = 8'd0;
                  run_b_in  = 8'd0;
                  length_in = 16'd0;
                  left_in   = 16'd0;
                  phase_in  = PH_TYPE;
               end else begin
                  res_valid  = 1'b1;
                  res.status = ST_BAD_SYNC;
                  phase_in   = PH_HUNT;
               end
            end
         endcase
      end
   end

   // output register with one skid entry
   assign drain = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || drain) begin
         // no accept while the skid holds something, so no new result then
         out_valid_in  = skid_valid_ff || res_valid;
         out_in        = skid_valid_ff ? skid_ff : res;
         skid_valid_in = 1'b0;
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         length_ff     <= 16'd0;
         left_ff       <= 16'd0;
         run_a_ff      <= 8'd0;
         run_b_ff      <= 8'd0;
         recv_a_ff     <= 8'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         length_ff     <= length_in;
         left_ff       <= left_in;
         run_a_ff      <= run_a_in;
         run_b_ff      <= run_b_in;
         recv_a_ff     <= recv_a_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_sum_a          = out_ff.sum_a;
   assign rsp_sum_b          = out_ff.sum_b;

`ifndef SYNTHESIS
   // skid entry only fills behind a waiting output transaction
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transaction while output register is empty");

   a_phase_used: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 3'd7)
      else $error("parser reached unused phase code");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.status == ST_OK || out_ff.status == ST_MISMATCH ||
                        out_ff.status == ST_BAD_SYNC))
      else $error("result carries an undefined status");

   a_sync_error_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status == ST_BAD_SYNC) |->
         (out_ff.payload_length == 16'd0 && out_ff.sum_a == 8'd0 && out_ff.sum_b == 8'd0))
      else $error("sync error result has nonzero fields");

   // a frame result always ends the frame
   a_result_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_CHECK_B) |=> phase_ff == PH_HUNT)
      else $error("parser did not return to hunting after check bytes");
`endif

endmodule
